// File: hdl/pism_pkg.sv
// ----------------------------------------------------------------------------
// pism_pkg
// Shared types, constants and decode functions of the pinyin-initial
// subsequence matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package pism_pkg;

    localparam int BYTE_W                  = 8;
    localparam int PAT_BYTES               = 16;  // bytes held by the two pattern registers
    localparam int PAT_REG_W               = 64;
    localparam int LEN_W                   = 5;
    localparam int CFG_IDX_W               = 2;
    localparam int MAX_PATTERN_BYTES_DEF   = 16;
    localparam int FIFO_DEPTH              = 4;
    localparam int CODE_W                  = 14;  // positive double-byte code
    localparam int SCODE_W                 = 16;  // signed working width of a code
    localparam int CHR_W                   = 9;   // signed single-character value

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW    = 2'd0,
        REG_PATTERN_HIGH   = 2'd1,
        REG_PATTERN_LENGTH = 2'd2
    } cfg_reg_t;

    // byte classes
    localparam logic [BYTE_W-1:0] BAD_LEAD_LO = 8'h80;
    localparam logic [BYTE_W-1:0] DBL_LEAD_LO = 8'hA0;
    localparam logic [BYTE_W-1:0] LOWER_A     = 8'h61;
    localparam logic [BYTE_W-1:0] LOWER_Z     = 8'h7A;
    localparam logic [CHR_W-1:0]  CASE_OFFSET = 9'd32;

    // code = (lead - 0xA0) * 100 + trail - 0xA0
    localparam logic [CODE_W-1:0]  CODE_ROW    = 14'd100;
    localparam logic [SCODE_W-1:0] CODE_BIAS   = 16'd160;
    localparam logic signed [SCODE_W-1:0] NARROW_LIM = 16'sd128;
    localparam logic signed [SCODE_W-1:0] SUBDBL_LIM = 16'sd160;

    localparam int N_INITIALS = 23;

    localparam logic [CODE_W-1:0] INITIAL_START [N_INITIALS+1] = '{
        14'd1601, 14'd1637, 14'd1833, 14'd2078, 14'd2274, 14'd2302,
        14'd2433, 14'd2594, 14'd2787, 14'd3106, 14'd3212, 14'd3472,
        14'd3635, 14'd3722, 14'd3730, 14'd3858, 14'd4027, 14'd4086,
        14'd4390, 14'd4558, 14'd4684, 14'd4925, 14'd5249, 14'd5590
    };

    localparam logic [BYTE_W-1:0] INITIAL_LETTER [N_INITIALS] = '{
        "A", "B", "C", "D", "E", "F", "G", "H", "J", "K", "L", "M",
        "N", "O", "P", "Q", "R", "S", "T", "W", "X", "Y", "Z"
    };

    // one evaluated character, name side
    typedef struct packed {
        logic              bad;      // lead byte 0x80-0x9F
        logic              narrow;   // code below 0x80
        logic              sub_dbl;  // code below 0xA0
        logic [CHR_W-1:0]  chr;      // folded character or pinyin initial
        logic [CODE_W-1:0] code;     // exact code, meaningful when !sub_dbl
    } name_desc_t;

    // one pattern position
    typedef struct packed {
        logic              bad;
        logic              narrow;
        logic [CHR_W-1:0]  chr;
        logic [CODE_W-1:0] code;
    } pat_desc_t;

    // queue word from front to back
    typedef struct packed {
        name_desc_t pair;   // held lead with this byte as trail
        name_desc_t fresh;  // this byte alone, trail taken as zero
        logic       hold;   // this byte would be held as a lead
        logic       last;
    } fifo_word_t;

    function automatic logic [SCODE_W-1:0] dbl_code(input logic [BYTE_W-1:0] lead,
                                                    input logic [BYTE_W-1:0] trail);
        logic [BYTE_W-1:0] off;
        logic [CODE_W-1:0] row;
        off = lead - DBL_LEAD_LO;
        row = CODE_W'(off[6:0]) * CODE_ROW;
        return {2'b00, row} + {8'h00, trail} - CODE_BIAS;
    endfunction

    function automatic logic [BYTE_W-1:0] initial_of(input logic [SCODE_W-1:0] code);
        logic [BYTE_W-1:0] letter;
        letter = '0;
        for (int k = 0; k < N_INITIALS; k++) begin
            if ($signed(code) >= $signed({2'b00, INITIAL_START[k]}) &&
                $signed(code) <  $signed({2'b00, INITIAL_START[k+1]}))
            begin
                letter = INITIAL_LETTER[k];
            end
        end
        return letter;
    endfunction

    function automatic logic [CHR_W-1:0] fold9(input logic [CHR_W-1:0] v);
        logic [CHR_W-1:0] r;
        r = v;
        if (!v[CHR_W-1] && v[7:0] >= LOWER_A && v[7:0] <= LOWER_Z)
        begin
            r = v - CASE_OFFSET;
        end
        return r;
    endfunction

    function automatic name_desc_t classify(input logic [SCODE_W-1:0] code);
        name_desc_t d;
        d.bad     = 1'b0;
        d.narrow  = $signed(code) < NARROW_LIM;
        d.sub_dbl = $signed(code) < SUBDBL_LIM;
        d.chr     = fold9(d.narrow ? code[CHR_W-1:0] : {1'b0, initial_of(code)});
        d.code    = code[CODE_W-1:0];
        return d;
    endfunction

endpackage

`default_nettype wire

// File: hdl/pism_if.sv
// ----------------------------------------------------------------------------
// pism_if
// Valid/ready channels of the matcher: name bytes in, match flags out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pism_name_if;
    logic       valid;
    logic       ready;
    logic [7:0] name_byte;
    logic       last_byte;

    modport source (output valid, output name_byte, output last_byte, input ready);
    modport sink   (input valid, input name_byte, input last_byte, output ready);
endinterface

interface pism_match_if;
    logic valid;
    logic ready;
    logic is_match;

    modport source (output valid, output is_match, input ready);
    modport sink   (input valid, input is_match, output ready);
endinterface

`default_nettype wire

// File: hdl/pism_pattern.sv
// ----------------------------------------------------------------------------
// pism_pattern
// Configuration registers and per-position pattern decode.
// ----------------------------------------------------------------------------
`default_nettype none

module pism_pattern
    import pism_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
    localparam int PW    = $clog2(MAX_PATTERN_BYTES + 1),
    localparam int IW    = $clog2(MAX_PATTERN_BYTES),
    localparam int POS_N = 2 ** IW
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PAT_REG_W-1:0] cfg_data,
    output logic [PW-1:0]        len_eff,
    output pat_desc_t            desc [POS_N]
);

    logic [PAT_REG_W-1:0] pattern_low_reg,    pattern_low_next;
    logic [PAT_REG_W-1:0] pattern_high_reg,   pattern_high_next;
    logic [LEN_W-1:0]     pattern_length_reg, pattern_length_next;
    logic [BYTE_W-1:0]    pat_byte [PAT_BYTES];

    always_comb
    begin
        pattern_low_next    = pattern_low_reg;
        pattern_high_next   = pattern_high_reg;
        pattern_length_next = pattern_length_reg;
        if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LOW:    pattern_low_next    = cfg_data;
                REG_PATTERN_HIGH:   pattern_high_next   = cfg_data;
                REG_PATTERN_LENGTH: pattern_length_next = cfg_data[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= '0;
        end
        else
        begin
            pattern_low_reg    <= pattern_low_next;
            pattern_high_reg   <= pattern_high_next;
            pattern_length_reg <= pattern_length_next;
        end
    end

    // lengths above the position count clamp
    assign len_eff = (pattern_length_reg > LEN_W'(MAX_PATTERN_BYTES))
                   ? PW'(MAX_PATTERN_BYTES) : pattern_length_reg[PW-1:0];

    for (genvar i = 0; i < PAT_BYTES; i++)
    begin : g_bytes
        if (i < 8)
        begin : g_lo
            assign pat_byte[i] = pattern_low_reg[8*i +: 8];
        end
        else
        begin : g_hi
            assign pat_byte[i] = pattern_high_reg[8*(i-8) +: 8];
        end
    end

    for (genvar p = 0; p < POS_N; p++)
    begin : g_pos
        if (p < MAX_PATTERN_BYTES)
        begin : g_used
            logic [BYTE_W-1:0]  b0;
            logic [BYTE_W-1:0]  b1;
            logic [SCODE_W-1:0] tc;
            name_desc_t         nd;

            assign b0 = (PW'(p) < len_eff) ? pat_byte[p] : '0;
            if (p + 1 < PAT_BYTES)
            begin : g_next
                assign b1 = (PW'(p + 1) < len_eff) ? pat_byte[p+1] : '0;
            end
            else
            begin : g_none
                assign b1 = '0;
            end

            assign tc = dbl_code(b0, b1);
            assign nd = classify(tc);

            always_comb
            begin
                if (b0 < BAD_LEAD_LO)
                begin
                    desc[p].bad    = 1'b0;
                    desc[p].narrow = 1'b1;
                    desc[p].chr    = fold9({1'b0, b0});
                    desc[p].code   = '0;
                end
                else if (b0 < DBL_LEAD_LO)
                begin
                    desc[p].bad    = 1'b1;
                    desc[p].narrow = 1'b0;
                    desc[p].chr    = '0;
                    desc[p].code   = '0;
                end
                else
                begin
                    desc[p].bad    = 1'b0;
                    desc[p].narrow = nd.narrow;
                    desc[p].chr    = nd.chr;
                    desc[p].code   = nd.code;
                end
            end
        end
        else
        begin : g_spare
            assign desc[p] = '0;
        end
    end

endmodule

`default_nettype wire

// File: hdl/pism_front.sv
// ----------------------------------------------------------------------------
// pism_front
// Takes name bytes and decodes each against its predecessor.
// ----------------------------------------------------------------------------
`default_nettype none

module pism_front
    import pism_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pism_name_if.sink  name,
    output fifo_word_t push_word,
    output logic       push,
    input  logic       full
);

    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg,  byte_next;
    logic [BYTE_W-1:0] prev_reg,  prev_next;
    logic              last_reg,  last_next;
    logic              accept;
    name_desc_t        dbl_fresh;

    assign push       = valid_reg && !full;
    assign name.ready = !valid_reg || !full;
    assign accept     = name.valid && name.ready;

    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        prev_next  = prev_reg;
        last_next  = last_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            byte_next  = name.name_byte;
            prev_next  = byte_reg;    // most recent byte taken so far
            last_next  = name.last_byte;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        prev_reg <= prev_next;
        last_reg <= last_next;
    end

    // pair is only used when the back end holds the previous byte as lead
    assign dbl_fresh = classify(dbl_code(byte_reg, '0));

    always_comb
    begin
        push_word.pair = classify(dbl_code(prev_reg, byte_reg));
        push_word.hold = (byte_reg >= DBL_LEAD_LO) && !last_reg;
        push_word.last = last_reg;
        if (byte_reg < BAD_LEAD_LO)
        begin
            push_word.fresh.bad     = 1'b0;
            push_word.fresh.narrow  = 1'b1;
            push_word.fresh.sub_dbl = 1'b1;
            push_word.fresh.chr     = fold9({1'b0, byte_reg});
            push_word.fresh.code    = '0;
        end
        else if (byte_reg < DBL_LEAD_LO)
        begin
            push_word.fresh         = '0;
            push_word.fresh.bad     = 1'b1;
        end
        else
        begin
            push_word.fresh = dbl_fresh;
        end
    end

endmodule

`default_nettype wire

// File: hdl/pism_fifo.sv
// ----------------------------------------------------------------------------
// pism_fifo
// Short queue of decoded words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module pism_fifo
    import pism_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  fifo_word_t push_word,
    output logic       full,
    input  logic       pop,
    output fifo_word_t pop_word,
    output logic       empty
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    fifo_word_t       store [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full     = (count_reg == CNT_W'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_word = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_word;
        end
    end

endmodule

`default_nettype wire

// File: hdl/pism_back.sv
// ----------------------------------------------------------------------------
// pism_back
// Match state per name: lead pairing, pattern position, failure, result.
// ----------------------------------------------------------------------------
`default_nettype none

module pism_back
    import pism_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
    localparam int PW    = $clog2(MAX_PATTERN_BYTES + 1),
    localparam int IW    = $clog2(MAX_PATTERN_BYTES),
    localparam int POS_N = 2 ** IW
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  fifo_word_t    pop_word,
    input  logic          empty,
    output logic          pop,
    input  logic [PW-1:0] len_eff,
    input  pat_desc_t     desc [POS_N],
    pism_match_if.source  result
);

    typedef struct packed {
        logic [PW-1:0] pos;
        logic          failed;
        logic          one;     // only the lead byte was used
    } eval_t;

    logic [PW-1:0] pos_reg,       pos_next;
    logic          failed_reg,    failed_next;
    logic          lead_held_reg, lead_held_next;
    logic          out_valid_reg, out_valid_next;
    logic          is_match_reg,  is_match_next;

    eval_t         ev_a;
    eval_t         ev_b;
    logic [PW-1:0] mid_pos;
    logic          mid_failed;
    logic          fresh_go;
    logic [PW-1:0] step_pos;
    logic          step_failed;
    logic          step_lead;
    logic          match_now;
    logic          out_free;

    function automatic eval_t eval_char(input logic [PW-1:0] pos,
                                        input logic          failed,
                                        input logic [PW-1:0] len,
                                        input pat_desc_t     pd,
                                        input name_desc_t    nd);
        eval_t       r;
        logic [PW:0] sum;
        r.pos    = pos;
        r.failed = failed;
        r.one    = 1'b0;
        sum      = {1'b0, pos};
        if (failed || pos >= len)
        begin
            r.one = 1'b0;
        end
        else if (pd.bad || nd.bad)
        begin
            r.failed = 1'b1;
        end
        else if (pd.narrow)
        begin
            r.one = nd.narrow;
            if (nd.chr == pd.chr)
            begin
                sum = {1'b0, pos} + (PW+1)'(1);
            end
        end
        else
        begin
            r.one = nd.sub_dbl;
            if (!nd.sub_dbl && nd.code == pd.code)
            begin
                sum = {1'b0, pos} + (PW+1)'(2);
            end
        end
        if (sum > {1'b0, len})
        begin
            sum = {1'b0, len};
        end
        r.pos = sum[PW-1:0];
        return r;
    endfunction

    assign out_free     = !out_valid_reg || result.ready;
    assign pop          = !empty && (!pop_word.last || out_free);
    assign result.valid    = out_valid_reg;
    assign result.is_match = is_match_reg;

    always_comb
    begin
        // held lead with this byte as trail
        ev_a = eval_char(pos_reg, failed_reg, len_eff, desc[pos_reg[IW-1:0]], pop_word.pair);
        if (lead_held_reg)
        begin
            mid_pos    = ev_a.pos;
            mid_failed = ev_a.failed;
            fresh_go   = ev_a.one;
        end
        else
        begin
            mid_pos    = pos_reg;
            mid_failed = failed_reg;
            fresh_go   = 1'b1;
        end

        // byte taken on its own
        ev_b = eval_char(mid_pos, mid_failed, len_eff, desc[mid_pos[IW-1:0]], pop_word.fresh);
        step_lead = fresh_go && pop_word.hold;
        if (fresh_go && !pop_word.hold)
        begin
            step_pos    = ev_b.pos;
            step_failed = ev_b.failed;
        end
        else
        begin
            step_pos    = mid_pos;
            step_failed = mid_failed;
        end

        match_now = !step_failed && (len_eff != '0) && (step_pos >= len_eff);

        pos_next       = pos_reg;
        failed_next    = failed_reg;
        lead_held_next = lead_held_reg;
        if (pop)
        begin
            if (pop_word.last)
            begin
                pos_next       = '0;
                failed_next    = 1'b0;
                lead_held_next = 1'b0;
            end
            else
            begin
                pos_next       = step_pos;
                failed_next    = step_failed;
                lead_held_next = step_lead;
            end
        end

        out_valid_next = out_valid_reg;
        is_match_next  = is_match_reg;
        if (pop && pop_word.last)
        begin
            out_valid_next = 1'b1;
            is_match_next  = match_now;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            failed_reg    <= 1'b0;
            lead_held_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            failed_reg    <= failed_next;
            lead_held_reg <= lead_held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_match_reg <= is_match_next;
    end

endmodule

`default_nettype wire

// File: hdl/pinyin_initial_subsequence_match.sv
// ----------------------------------------------------------------------------
// pinyin_initial_subsequence_match
// Greedy subsequence match of a file name against a pattern of ASCII letters
// (matching ASCII or GB2312 characters by pinyin initial) and GB2312 codes.
// ----------------------------------------------------------------------------
// Usage:
//   name   : one word per name byte, last_byte set on the final byte.
//   result : one word per name, sent after the last byte; is_match is set
//            when the whole pattern was found in order.
//   cfg    : cfg_write/cfg_index/cfg_data load pattern_low (0), pattern_high
//            (1) and pattern_length (2); write only while the block is idle.
// Timing: one name byte per cycle, sustained while result.ready stays high.
//   The result word is registered in the front decode register, then in a
//   queue entry, then by the back end's match update in the output register.
//   The rate is set by the back end's state update, which handles a
//   lead/trail pair and a following fresh byte in one step.
// Reset: pattern registers clear to zero (empty pattern: never match), the
//   queue empties and any partial name is dropped.
// Stall: while result.ready is low the finished flag waits in the output
//   register; bytes of the next name keep flowing until its own last byte
//   reaches the back end, then the four-word queue and front fill up and
//   name.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module pinyin_initial_subsequence_match
    import pism_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    pism_name_if.sink            name,
    pism_match_if.source         result,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PAT_REG_W-1:0] cfg_data
);

    localparam int PW    = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int IW    = $clog2(MAX_PATTERN_BYTES);
    localparam int POS_N = 2 ** IW;

    // front -> queue
    fifo_word_t push_word;
    logic       push;
    logic       full;

    // queue -> back
    fifo_word_t pop_word;
    logic       pop;
    logic       empty;

    // pattern decode: the user keeps it steady while a name is in flight; the block leaves this to them
    logic [PW-1:0] len_eff;
    pat_desc_t     desc [POS_N];

    pism_pattern #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_pattern (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .len_eff   (len_eff),
        .desc      (desc)
    );

    // front: registers each byte and decodes it alone and as a trail
    pism_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .name      (name),
        .push_word (push_word),
        .push      (push),
        .full      (full)
    );

    pism_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (full),
        .pop       (pop),
        .pop_word  (pop_word),
        .empty     (empty)
    );

    // back: match state and result register
    pism_back #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop_word (pop_word),
        .empty    (empty),
        .pop      (pop),
        .len_eff  (len_eff),
        .desc     (desc),
        .result   (result)
    );

endmodule

`default_nettype wire

// File: test/tb_pinyin_initial_subsequence_match.sv
// ----------------------------------------------------------------------------
// tb_pinyin_initial_subsequence_match
// Self-checking bench for the pinyin-initial subsequence matcher. Name bytes
// are streamed through the valid/ready channel. A built-in predictor scores
// each finished name, and every returned match word is compared with the
// oldest prediction. A short directed block comes first. Random phases
// follow, each with its own pattern, and the patterns range from extremes
// to partly broken ones. Both sides stall at random but in the full-pattern phase.
// ----------------------------------------------------------------------------
module tb_pinyin_initial_subsequence_match;
    timeunit 1ns;
    timeprecision 1ps;

    import pism_pkg::*;

    // ------------------------------------------------------------------------
    // Constants
    // ------------------------------------------------------------------------
    localparam int PAT_CAP     = 16;      // pattern byte cap of the DUT instance
    localparam int ASCII_END   = 128;     // codes below this are single characters
    localparam int LEAD_BASE   = 160;     // first valid double-byte lead / code bias
    localparam int CODE_STRIDE = 100;     // code = row * 100 + column
    localparam int LIMIT       = 200000;  // timeout in clock cycles
    localparam int SETTLE      = 8;       // idle cycles before a register write / the end
    localparam int PHASES      = 12;
    localparam int HALF_PHASE  = 75;      // name bytes between sender pauses

    // pattern set-ups of the random phases
    localparam int MODE_ALL_ONES = 0;
    localparam int MODE_EMPTY    = 1;
    localparam int MODE_FULL     = 2;
    localparam int MODE_RANDOM   = 3;

    // start code of each pinyin initial range; the last entry closes the table
    localparam int LETTER_FROM [24] = '{
        1601, 1637, 1833, 2078, 2274, 2302, 2433, 2594, 2787, 3106, 3212, 3472,
        3635, 3722, 3730, 3858, 4027, 4086, 4390, 4558, 4684, 4925, 5249, 5590
    };
    localparam int LETTER_OF [23] = '{
        "A", "B", "C", "D", "E", "F", "G", "H", "J", "K", "L", "M",
        "N", "O", "P", "Q", "R", "S", "T", "W", "X", "Y", "Z"
    };

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } name_word_t;

    // one pattern character as the name generator sees it
    typedef struct packed {
        logic       dbl;
        logic [7:0] b0;
        logic [7:0] b1;
    } pat_char_t;

    // ------------------------------------------------------------------------
    // Clock, channels, DUT
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    cfg_reg_t    cfg_index;
    logic [63:0] cfg_data;

    pism_name_if  name_ch ();
    pism_match_if match_ch ();

    pinyin_initial_subsequence_match #(
        .MAX_PATTERN_BYTES (PAT_CAP)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .name      (name_ch),
        .result    (match_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    name_word_t  pending [$];     // name words waiting for the driver
    name_word_t  next_word;
    bit          match_due [$];   // predicted is_match per finished name
    logic [7:0]  name_buf [$];    // scratch for the name being built
    pat_char_t   pat_chars [$];   // characters of the current pattern
    int          sent_items = 0;
    int          errors     = 0;
    int          cycles     = 0;
    int          send_idle  = 17; // percent of cycles each side holds off
    int          recv_idle  = 17;
    int          verdict;
    bit          due;

    // predictor's copy of the registers and of the name state
    logic [63:0] pat_lo    = '0;
    logic [63:0] pat_hi    = '0;
    logic [4:0]  pat_len   = '0;
    int          pos       = 0;
    int          held_lead = 0;
    bit          lead_held = 1'b0;
    bit          failed    = 1'b0;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic int pat_span();
        return (int'(pat_len) > PAT_CAP) ? PAT_CAP : int'(pat_len);
    endfunction

    // bytes past the length read as zero, so a trailing lead gets trail zero
    function automatic int pat_byte_at(input int i);
        if (i >= pat_span())
            return 0;
        if (i < 8)
            return int'(pat_lo[8*i +: 8]);
        return int'(pat_hi[8*(i-8) +: 8]);
    endfunction

    // codes outside every range give 0, which then matches a pattern byte 0x00
    function automatic int pinyin_letter(input int code);
        int k;
        for (k = 0; k < 23; k++)
        begin
            if (code >= LETTER_FROM[k] && code < LETTER_FROM[k+1])
                return LETTER_OF[k];
        end
        return 0;
    endfunction

    function automatic int upcase(input int v);
        return (v >= 97 && v <= 122) ? v - 32 : v;
    endfunction

    // Score one name character (lead s, trail t) against the pattern position.
    // Returns the name bytes it used: 1 when the trail must start a new one.
    function automatic int consume_char(input int s, input int t);
        int span;
        int pc;
        int want;
        int got;
        int c;
        int used;
        span = pat_span();
        if (failed || pos >= span)
            return 2;
        pc = pat_byte_at(pos);
        if (pc < ASCII_END)
            want = pc;
        else if (pc < LEAD_BASE)
        begin
            failed = 1'b1;
            return 2;
        end
        else
            want = (pc - LEAD_BASE) * CODE_STRIDE + pat_byte_at(pos + 1) - LEAD_BASE;
        if (s < ASCII_END)
            got = s;
        else if (s < LEAD_BASE)
        begin
            failed = 1'b1;
            return 2;
        end
        else
            got = (s - LEAD_BASE) * CODE_STRIDE + t - LEAD_BASE;
        if (want < ASCII_END)
        begin
            // single pattern character: ASCII or pinyin initial, any case
            if (got < ASCII_END)
            begin
                used = 1;
                c    = got;
            end
            else
            begin
                used = 2;
                c    = pinyin_letter(got);
            end
            if (upcase(c) == upcase(want))
                pos++;
        end
        else
        begin
            // double-byte pattern character: exact code only
            if (got < LEAD_BASE)
                used = 1;
            else
            begin
                used = 2;
                if (got == want)
                    pos += 2;
            end
        end
        if (pos > span)
            pos = span;
        return used;
    endfunction

    // a lead byte waits for its trail unless it ends the name
    function automatic void take_byte(input int b, input bit last);
        if (b >= LEAD_BASE && !last)
        begin
            held_lead = b;
            lead_held = 1'b1;
        end
        else
            void'(consume_char(b, 0));
    endfunction

    // Returns -1 mid-name, else the flag due for the finished name.
    function automatic int step_name_byte(input int b, input bit last);
        int lead;
        int flag;
        if (lead_held)
        begin
            lead      = held_lead;
            lead_held = 1'b0;
            held_lead = 0;
            if (consume_char(lead, b) == 1)
                take_byte(b, last);
        end
        else
            take_byte(b, last);
        if (!last)
            return -1;
        flag      = (!failed && pat_span() > 0 && pos >= pat_span()) ? 1 : 0;
        pos       = 0;
        held_lead = 0;
        lead_held = 1'b0;
        failed    = 1'b0;
        return flag;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: one name word per handshake, random hold-offs
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            name_ch.valid     <= 1'b0;
            name_ch.name_byte <= '0;
            name_ch.last_byte <= 1'b0;
        end
        else if (!name_ch.valid || name_ch.ready)
        begin
            if (pending.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                next_word = pending.pop_front();
                name_ch.valid     <= 1'b1;
                name_ch.name_byte <= next_word.b;
                name_ch.last_byte <= next_word.last;
            end
            else
                name_ch.valid <= 1'b0;
        end
    end

    // receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            match_ch.ready <= 1'b0;
        else
            match_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    // ------------------------------------------------------------------------
    // Monitor: tracks register writes, predicts on every accepted name word
    // and checks every accepted match word against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pat_lo    = '0;
            pat_hi    = '0;
            pat_len   = '0;
            pos       = 0;
            held_lead = 0;
            lead_held = 1'b0;
            failed    = 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_PATTERN_LOW:    pat_lo  = cfg_data;
                    REG_PATTERN_HIGH:   pat_hi  = cfg_data;
                    REG_PATTERN_LENGTH: pat_len = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (name_ch.valid && name_ch.ready)
            begin
                verdict = step_name_byte(int'(name_ch.name_byte), name_ch.last_byte);
                if (verdict >= 0)
                    match_due.insert(match_due.size(), verdict[0]);
            end
            if (match_ch.valid && match_ch.ready)
            begin
                if (match_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: is_match word, expected none, actual %0b",
                             $time, match_ch.is_match);
                end
                else
                begin
                    due = match_due.pop_front();
                    if (match_ch.is_match !== due)
                    begin
                        errors++;
                        $display("%0t: is_match mismatch, expected %0b, actual %0b",
                                 $time, due, match_ch.is_match);
                    end
                end
            end
        end
    end

    // timeout watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void push_byte(input logic [7:0] b, input bit last);
        name_word_t w;
        w.b    = b;
        w.last = last;
        pending.insert(pending.size(), w);
        sent_items++;
    endfunction

    // append one byte to the name being built
    function automatic void add_byte(input logic [7:0] b);
        name_buf.insert(name_buf.size(), b);
    endfunction

    // first byte of the name in the highest used byte of text
    function automatic void queue_literal(input logic [63:0] text, input int n);
        int j;
        for (j = 0; j < n; j++)
            push_byte(text[8*(n-1-j) +: 8], j == n - 1);
    endfunction

    function automatic void add_db(input int code);
        add_byte(8'(code / CODE_STRIDE + LEAD_BASE));
        add_byte(8'(code % CODE_STRIDE + LEAD_BASE));
    endfunction

    // random code inside the range of an initial, -1 if the letter has none
    function automatic int code_for_letter(input int up);
        int k;
        int code;
        for (k = 0; k < 23; k++)
        begin
            if (LETTER_OF[k] == up)
            begin
                code = $urandom_range(LETTER_FROM[k], LETTER_FROM[k+1] - 1);
                while (code % CODE_STRIDE == 0 || code % CODE_STRIDE > 94)
                    code = $urandom_range(LETTER_FROM[k], LETTER_FROM[k+1] - 1);
                return code;
            end
        end
        return -1;
    endfunction

    // printable ASCII, a double-byte character (inside or outside the table),
    // or any byte at all
    function automatic void add_filler();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            add_byte(8'($urandom_range(32, 126)));
        else if (r < 90)
        begin
            add_byte(8'($urandom_range(161, 255)));
            add_byte(8'($urandom_range(161, 254)));
        end
        else
            add_byte(8'($urandom_range(255)));
    endfunction

    // a name character meant to satisfy the pattern character
    function automatic void add_like(input pat_char_t pc);
        int up;
        int code;
        up = upcase(int'(pc.b0));
        if (pc.dbl)
        begin
            add_byte(pc.b0);
            add_byte(pc.b1);
        end
        else if (up >= 65 && up <= 90)
        begin
            code = $urandom_range(1) ? code_for_letter(up) : -1;
            if (code >= 0)
                add_db(code);
            else
                add_byte(8'($urandom_range(1) ? up : up + 32));
        end
        else if (pc.b0 == 8'h00 && $urandom_range(1))
        begin
            // double-byte code past the table: initial 0
            add_byte(8'($urandom_range(248, 255)));
            add_byte(8'($urandom_range(161, 254)));
        end
        else
            add_byte(pc.b0);
    endfunction

    // Mostly names built around the pattern with random fillers; some of them
    // broken (a character dropped, a bad lead inserted, a lone lead at the end);
    // a quarter pure noise.
    function automatic void queue_name();
        int roll;
        int drop;
        int k;
        roll = $urandom_range(99);
        name_buf.delete();
        if (roll < 25)
        begin
            repeat ($urandom_range(1, 10))
                add_byte(8'($urandom_range(255)));
        end
        else
        begin
            drop = (roll < 35 && pat_chars.size() != 0) ?
                   $urandom_range(pat_chars.size() - 1) : -1;
            for (k = 0; k < pat_chars.size(); k++)
            begin
                if ($urandom_range(3) == 0)
                    add_filler();
                if (k != drop)
                    add_like(pat_chars[k]);
            end
            repeat ($urandom_range(0, 2))
                add_filler();
            if (name_buf.size() == 0)
                add_filler();
            if (roll >= 35 && roll < 42)
                name_buf.insert($urandom_range(name_buf.size() - 1),
                                8'($urandom_range(128, 159)));
            if (roll >= 42 && roll < 48)
                add_byte(8'($urandom_range(160, 255)));
        end
        for (k = 0; k < name_buf.size(); k++)
            push_byte(name_buf[k], k == name_buf.size() - 1);
    endfunction

    function automatic pat_char_t random_pat_char();
        pat_char_t pc;
        int        r;
        r      = $urandom_range(99);
        pc.dbl = 1'b0;
        pc.b1  = '0;
        if (r < 45)
            pc.b0 = 8'($urandom_range(25) + ($urandom_range(1) ? 65 : 97));
        else if (r < 70)
        begin
            pc.dbl = 1'b1;
            pc.b0  = 8'($urandom_range(161, 247));
            pc.b1  = 8'($urandom_range(161, 254));
        end
        else if (r < 80)
            pc.b0 = 8'($urandom_range(127));
        else if (r < 85)
            pc.b0 = 8'($urandom_range(128, 159));   // bad lead in the pattern
        else
        begin
            // any lead and trail: small codes, odd trails
            pc.dbl = 1'b1;
            pc.b0  = 8'($urandom_range(160, 255));
            pc.b1  = 8'($urandom_range(255));
        end
        return pc;
    endfunction

    // ------------------------------------------------------------------------
    // Sequencing tasks
    // ------------------------------------------------------------------------
    // Three register writes on consecutive edges; only called while idle.
    task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [4:0] len);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_PATTERN_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= REG_PATTERN_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= REG_PATTERN_LENGTH;
        cfg_data  <= 64'(len);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // sender holds off until every name word is in and every flag is back
    task automatic wait_drained();
        @(negedge clk);
        while (pending.size() != 0 || name_ch.valid || match_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic new_pattern(input int mode);
        logic [127:0] img;   // pattern byte 0 in bits 7..0
        pat_char_t    pc;
        int           nbytes;
        int           nchars;
        int           len;
        int           r;
        pat_chars.delete();
        img    = {$urandom, $urandom, $urandom, $urandom};   // junk past the length
        nbytes = 0;
        if (mode == MODE_ALL_ONES)
        begin
            img    = '1;
            len    = 31;
            pc.dbl = 1'b1;
            pc.b0  = 8'hFF;
            pc.b1  = 8'hFF;
            repeat (8) pat_chars.insert(pat_chars.size(), pc);
        end
        else if (mode == MODE_EMPTY)
        begin
            img = '0;
            len = 0;
        end
        else
        begin
            nchars = (mode == MODE_FULL) ? PAT_CAP : $urandom_range(1, 6);
            while (pat_chars.size() < nchars && nbytes < PAT_CAP)
            begin
                pc = random_pat_char();
                if (pc.dbl && nbytes == PAT_CAP - 1)
                begin
                    pc.dbl = 1'b0;
                    pc.b0  = 8'($urandom_range(65, 90));
                end
                img[8*nbytes +: 8] = pc.b0;
                if (pc.dbl)
                    img[8*(nbytes+1) +: 8] = pc.b1;
                nbytes += pc.dbl ? 2 : 1;
                pat_chars.insert(pat_chars.size(), pc);
            end
            r = $urandom_range(99);
            if (mode == MODE_FULL || r < 80)
                len = nbytes;
            else if (r < 86)
                len = 0;
            else if (r < 93)
                len = $urandom_range(17, 31);   // above the cap
            else
                len = nbytes - 1;               // may cut a trail off
        end
        load_pattern(img[63:0], img[127:64], 5'(len));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int ph;
        int target;
        int mode;

        name_ch.valid     = 1'b0;
        name_ch.name_byte = '0;
        name_ch.last_byte = 1'b0;
        match_ch.ready    = 1'b0;
        cfg_write         = 1'b0;
        cfg_index         = REG_PATTERN_LOW;
        cfg_data          = '0;
        rst_n             = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed ----
        // empty pattern out of reset: never a match
        queue_literal(64'h41, 1);
        wait_drained();

        // pattern "a", B0A1, "Z"
        load_pattern(64'h5AA1_B061, 64'h0, 5'd4);
        queue_literal(64'h41B0_A17A, 4);             // case folding, exact code
        queue_literal(64'hB0A1_B0A1_D6D0_85, 7);     // initials; bad byte after the end
        queue_literal(64'h90, 1);                    // bad lead in the name
        queue_literal(64'h41B0, 2);                  // lead as last byte, trail zero
        queue_literal(64'h41A0_41B0_A15A, 6);        // small code gives back its trail
        wait_drained();

        // pattern byte 0x00 against a code outside the table
        load_pattern(64'h0, 64'h0, 5'd1);
        queue_literal(64'hF7FE, 2);
        wait_drained();

        // bad lead in the pattern
        load_pattern(64'h85, 64'h0, 5'd1);
        queue_literal(64'h61, 1);
        wait_drained();

        // ---- random phases ----
        for (ph = 0; ph < PHASES; ph++)
        begin
            mode = (ph < MODE_RANDOM) ? ph : MODE_RANDOM;
            // the full-pattern phase runs with no stalls on either side
            send_idle = (mode == MODE_FULL) ? 0 : 17;
            recv_idle = (mode == MODE_FULL) ? 0 : 17;
            new_pattern(mode);
            target = sent_items + HALF_PHASE;
            while (sent_items < target)
                queue_name();
            wait_drained();
            target = sent_items + HALF_PHASE;
            while (sent_items < target)
                queue_name();
            wait_drained();
        end

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
